@@ rtl/fcba_pkg.sv @@
// ----------------------------------------------------------------------------
// fcba_pkg
// Shared sizes, command and status codes, and the formatted table contents
// for the chained block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcba_pkg;

   localparam int NUM_BLOCKS = 256;
   localparam int DIR_SLOTS  = 16;
   localparam int BLK_W      = $clog2(NUM_BLOCKS);
   localparam int SLOT_W     = $clog2(DIR_SLOTS);
   localparam int CNT_W      = BLK_W + 1;
   localparam int CMD_W      = 3;
   localparam int STAT_W     = 3;

   localparam logic [BLK_W-1:0] RESET_FIRST_FREE = BLK_W'(15);
   localparam logic [BLK_W-1:0] MIN_FIRST_FREE   = BLK_W'(2);
   localparam logic [BLK_W-1:0] LAST_BLOCK       = BLK_W'(NUM_BLOCKS - 1);
   localparam logic [BLK_W-1:0] RESERVED_MARK    = BLK_W'(1);
   localparam logic [BLK_W-1:0] FREE_HEAD        = '0;
   localparam logic [BLK_W-1:0] END_OF_CHAIN     = '0;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_ADD    = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_CHECK  = 3'd4,
      CMD_NEXT   = 3'd5,
      CMD_FIRST  = 3'd6
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK           = 3'd0,
      ST_UNUSED       = 3'd1,
      ST_NOT_IN_CHAIN = 3'd2,
      ST_FULL         = 3'd3,
      ST_IN_USE       = 3'd4
   } status_type;

   // Table entry as left by a format with the given first free block.
   function automatic logic [BLK_W-1:0] fmt_entry(input logic [BLK_W-1:0] idx,
                                                  input logic [BLK_W-1:0] ffb);
      logic [BLK_W-1:0] f;
      logic [BLK_W-1:0] res;
      f = (ffb < MIN_FIRST_FREE) ? MIN_FIRST_FREE : ffb;
      if (idx == FREE_HEAD) begin
         res = f;
      end else if (idx < f) begin
         res = RESERVED_MARK;
      end else if (idx == LAST_BLOCK) begin
         res = END_OF_CHAIN;
      end else begin
         res = idx + RESERVED_MARK;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/fat_chain_block_allocator.sv @@
// ----------------------------------------------------------------------------
// fat_chain_block_allocator
// Allocation table with a free list at entry 0 and a directory of slots,
// each holding the first block of a chain. One command per item.
// ----------------------------------------------------------------------------
// The chain walk of check, next, add and delete reads one table entry per cycle from
// the table RAM; create, remove, first and rejected items do no walk. One item at a
// time; the next item is taken once the result is registered. Reset clears the
// directory and marks every table entry as formatted, so the table is usable at once;
// a register write reformats.
`timescale 1ns / 1ps
`default_nettype none

module fat_chain_block_allocator
   import fcba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [CMD_W-1:0]  req_command,
   input  wire logic [SLOT_W-1:0] req_slot,
   input  wire logic [BLK_W-1:0]  req_block_number,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [STAT_W-1:0] rsp_status,
   output      logic [BLK_W-1:0]  rsp_value,
   output      logic              rsp_is_member,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [BLK_W-1:0]  csr_first_free_block
);

   typedef enum logic [12:0] {
      S_IDLE       = 13'b0000000000001,
      S_DISPATCH   = 13'b0000000000010,
      S_ADD_HEAD   = 13'b0000000000100,
      S_ADD_POP    = 13'b0000000001000,
      S_ADD_CLR    = 13'b0000000010000,
      S_ADD_WSTART = 13'b0000000100000,
      S_TAIL       = 13'b0000001000000,
      S_MCHK       = 13'b0000010000000,
      S_PWALK      = 13'b0000100000000,
      S_DEL_HEAD   = 13'b0001000000000,
      S_DEL_PUSH   = 13'b0010000000000,
      S_DEL_TOP    = 13'b0100000000000,
      S_FINISH     = 13'b1000000000000
   } state_type;

   localparam logic [CNT_W-1:0] WALK_LIMIT = CNT_W'(NUM_BLOCKS);

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [BLK_W-1:0]  ffb_ff;
   logic [BLK_W-1:0]  a_ff, a_in;
   logic [BLK_W-1:0]  nxt_ff, nxt_in;
   logic [BLK_W-1:0]  b_ff, b_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   status_type        res_status_ff, res_status_in;
   logic [BLK_W-1:0]  res_value_ff, res_value_in;
   logic              res_member_ff, res_member_in;

   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [BLK_W-1:0]  rsp_value_ff;
   logic              rsp_member_ff;
   logic              rsp_load;

   logic                slot_used_ff [DIR_SLOTS];
   logic [BLK_W-1:0]    slot_first_ff [DIR_SLOTS];
   logic                slot_wr_en;
   logic                slot_used_val;
   logic [BLK_W-1:0]    slot_first_val;
   logic                cur_used;
   logic [BLK_W-1:0]    cur_first;

   logic [BLK_W-1:0]      mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] vld_ff;
   logic                  mem_rd_en;
   logic [BLK_W-1:0]      mem_raddr;
   logic                  mem_wr_en;
   logic [BLK_W-1:0]      mem_waddr;
   logic [BLK_W-1:0]      mem_wdata;
   logic [BLK_W-1:0]      rd_q;
   logic                  vld_q;
   logic [BLK_W-1:0]      rd_addr_q;
   logic [BLK_W-1:0]      rd_val;
   logic                  csr_fire;

   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_fire  = csr_valid && csr_ready;

   assign cur_used  = slot_used_ff[slot_ff];
   assign cur_first = slot_first_ff[slot_ff];

   assign rd_val = vld_q ? rd_q : fmt_entry(rd_addr_q, ffb_ff);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_is_member = rsp_member_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      slot_in        = slot_ff;
      blk_in         = blk_ff;
      a_in           = a_ff;
      nxt_in         = nxt_ff;
      b_in           = b_ff;
      n_in           = n_ff;
      res_status_in  = res_status_ff;
      res_value_in   = res_value_ff;
      res_member_in  = res_member_ff;
      mem_rd_en      = 1'b0;
      mem_raddr      = '0;
      mem_wr_en      = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;
      slot_wr_en     = 1'b0;
      slot_used_val  = 1'b0;
      slot_first_val = '0;
      rsp_load       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in        = cmd_type'(req_command);
               slot_in       = req_slot;
               blk_in        = req_block_number;
               res_status_in = ST_OK;
               res_value_in  = '0;
               res_member_in = 1'b0;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            case (cmd_ff)
               CMD_CREATE: begin
                  if (cur_used) begin
                     res_status_in = ST_IN_USE;
                  end else begin
                     slot_wr_en    = 1'b1;
                     slot_used_val = 1'b1;
                  end
               end
               CMD_REMOVE, CMD_ADD, CMD_DELETE, CMD_CHECK, CMD_NEXT, CMD_FIRST: begin
                  if (!cur_used) begin
                     res_status_in = ST_UNUSED;
                  end else begin
                     case (cmd_ff)
                        CMD_REMOVE: begin
                           slot_wr_en = 1'b1;
                        end
                        CMD_FIRST: begin
                           res_value_in = cur_first;
                        end
                        CMD_ADD: begin
                           mem_rd_en = 1'b1;
                           mem_raddr = FREE_HEAD;
                           state_in  = S_ADD_HEAD;
                        end
                        CMD_DELETE, CMD_CHECK, CMD_NEXT: begin
                           mem_rd_en = 1'b1;
                           mem_raddr = cur_first;
                           b_in      = cur_first;
                           n_in      = '0;
                           state_in  = S_MCHK;
                        end
                        default: begin
                           state_in = S_FINISH;
                        end
                     endcase
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_ADD_HEAD: begin
            if (rd_val == END_OF_CHAIN) begin
               res_status_in = ST_FULL;
               state_in      = S_FINISH;
            end else begin
               a_in      = rd_val;
               mem_rd_en = 1'b1;
               mem_raddr = rd_val;
               state_in  = S_ADD_POP;
            end
         end
         S_ADD_POP: begin
            mem_wr_en = 1'b1;
            mem_waddr = FREE_HEAD;
            mem_wdata = rd_val;
            state_in  = S_ADD_CLR;
         end
         S_ADD_CLR: begin
            mem_wr_en    = 1'b1;
            mem_waddr    = a_ff;
            mem_wdata    = END_OF_CHAIN;
            res_value_in = a_ff;
            if (cur_first == END_OF_CHAIN) begin
               slot_wr_en     = 1'b1;
               slot_used_val  = 1'b1;
               slot_first_val = a_ff;
               state_in       = S_FINISH;
            end else begin
               state_in = S_ADD_WSTART;
            end
         end
         S_ADD_WSTART: begin
            mem_rd_en = 1'b1;
            mem_raddr = cur_first;
            b_in      = cur_first;
            n_in      = '0;
            state_in  = S_TAIL;
         end
         S_TAIL: begin
            if (n_ff == WALK_LIMIT || rd_val == END_OF_CHAIN) begin
               mem_wr_en = 1'b1;
               mem_waddr = b_ff;
               mem_wdata = a_ff;
               state_in  = S_FINISH;
            end else begin
               b_in      = rd_val;
               n_in      = n_ff + 1'b1;
               mem_rd_en = 1'b1;
               mem_raddr = rd_val;
            end
         end
         S_MCHK: begin
            if (n_ff == WALK_LIMIT || b_ff == END_OF_CHAIN) begin
               if (cmd_ff != CMD_CHECK) begin
                  res_status_in = ST_NOT_IN_CHAIN;
               end
               state_in = S_FINISH;
            end else if (b_ff == blk_ff) begin
               case (cmd_ff)
                  CMD_CHECK: begin
                     res_member_in = 1'b1;
                     state_in      = S_FINISH;
                  end
                  CMD_NEXT: begin
                     res_value_in = rd_val;
                     state_in     = S_FINISH;
                  end
                  default: begin
                     nxt_in = rd_val;
                     if (cur_first == blk_ff) begin
                        slot_wr_en     = 1'b1;
                        slot_used_val  = 1'b1;
                        slot_first_val = rd_val;
                        state_in       = S_DEL_HEAD;
                     end else begin
                        mem_rd_en = 1'b1;
                        mem_raddr = cur_first;
                        b_in      = cur_first;
                        n_in      = '0;
                        state_in  = S_PWALK;
                     end
                  end
               endcase
            end else begin
               b_in      = rd_val;
               n_in      = n_ff + 1'b1;
               mem_rd_en = 1'b1;
               mem_raddr = rd_val;
            end
         end
         S_PWALK: begin
            if (n_ff == WALK_LIMIT || rd_val == blk_ff) begin
               mem_wr_en = 1'b1;
               mem_waddr = b_ff;
               mem_wdata = nxt_ff;
               state_in  = S_DEL_HEAD;
            end else begin
               b_in      = rd_val;
               n_in      = n_ff + 1'b1;
               mem_rd_en = 1'b1;
               mem_raddr = rd_val;
            end
         end
         S_DEL_HEAD: begin
            mem_rd_en = 1'b1;
            mem_raddr = FREE_HEAD;
            state_in  = S_DEL_PUSH;
         end
         S_DEL_PUSH: begin
            mem_wr_en = 1'b1;
            mem_waddr = blk_ff;
            mem_wdata = rd_val;
            state_in  = S_DEL_TOP;
         end
         S_DEL_TOP: begin
            mem_wr_en = 1'b1;
            mem_waddr = FREE_HEAD;
            mem_wdata = blk_ff;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ffb_ff       <= RESET_FIRST_FREE;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         for (int i = 0; i < DIR_SLOTS; i++) begin
            slot_used_ff[i]  <= 1'b0;
            slot_first_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            ffb_ff <= csr_first_free_block;
            vld_ff <= '0;
         end else if (mem_wr_en) begin
            vld_ff[mem_waddr] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (slot_wr_en) begin
            slot_used_ff[slot_ff]  <= slot_used_val;
            slot_first_ff[slot_ff] <= slot_first_val;
         end
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      blk_ff        <= blk_in;
      a_ff          <= a_in;
      nxt_ff        <= nxt_in;
      b_ff          <= b_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_member_ff <= res_member_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_member_ff <= res_member_ff;
      end
   end

   // allocation table RAM
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_rd_en) begin
         rd_q      <= mem[mem_raddr];
         vld_q     <= vld_ff[mem_raddr];
         rd_addr_q <= mem_raddr;
      end
   end

   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en && mem_rd_en |-> mem_waddr != mem_raddr)
      else $error("table read and write hit the same entry in one cycle");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAIL || state_ff == S_MCHK || state_ff == S_PWALK) |->
      n_ff <= WALK_LIMIT)
      else $error("chain walk ran past the block count");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff)
      else $error("finished item not presented");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == '0 && !rsp_member_ff)
      else $error("error result carries a value");

   a_csr_reformat: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> vld_ff == '0)
      else $error("register write did not reformat the table");

endmodule

`default_nettype wire
